// File: rtl/core/msqrt_pkg.sv
`default_nettype none
package msqrt_pkg;
    localparam int unsigned MAX_BITS = 64;
    localparam logic [12:0] NONRES_LIMIT = 13'd4096;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NONRES = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [63:0] MODULUS_RESET = 64'd18446744073709551557;
endpackage
`default_nettype wire

// File: rtl/core/msqrt_if.sv
`default_nettype none
interface msqrt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface msqrt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] root_one;
    logic [63:0] root_two;
    logic [1:0]  status;
    modport source (output valid, output root_one, output root_two, output status, input ready);
    modport sink (input valid, input root_one, input root_two, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/msqrt_mulmod.sv
`default_nettype none
// shift-and-add modular multiplier, one bit of b per cycle
module msqrt_mulmod #(
    parameter int unsigned FIELD_BITS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [FIELD_BITS-1:0] i_a,
    input  wire logic [FIELD_BITS-1:0] i_b,
    input  wire logic [FIELD_BITS-1:0] i_p,
    output logic                       o_done,
    output logic [FIELD_BITS-1:0]      o_prod
);
    localparam int unsigned CW = $clog2(FIELD_BITS + 1);
    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [FIELD_BITS-1:0] r_acc, r_a, r_b;
    logic [FIELD_BITS:0]   dbl, dsum;
    logic [FIELD_BITS-1:0] n_dbl, n_acc;

    // double then conditionally add, both reduced by one subtract
    always_comb begin
        dbl   = {r_acc, 1'b0};
        n_dbl = (dbl >= {1'b0, i_p}) ? FIELD_BITS'(dbl - {1'b0, i_p}) : dbl[FIELD_BITS-1:0];
        dsum  = {1'b0, n_dbl} + {1'b0, r_a};
        n_acc = n_dbl;
        if (r_b[FIELD_BITS-1]) begin
            n_acc = (dsum >= {1'b0, i_p}) ? FIELD_BITS'(dsum - {1'b0, i_p})
                                          : dsum[FIELD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FIELD_BITS);
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= {r_b[FIELD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// File: rtl/core/modular_square_root.sv
`default_nettype none
// Modular square root by Tonelli-Shanks over a configured prime modulus. One value is taken
// at a time; the block is not ready until its result beat has been taken. Every modular
// multiply runs on one shared shift-and-add multiplier, so an item's time grows with its
// multiplies: up to 2*FIELD_BITS multiplies for the Legendre test and each further
// exponentiation, plus the non-residue search (one exponentiation per candidate) and the
// squaring loop. Reduction of the value modulo p uses a restoring divider, one quotient
// bit per cycle.
module modular_square_root #(
    parameter int unsigned FIELD_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_data,
    msqrt_in_if.sink         i_in,
    msqrt_out_if.source      o_out
);
    localparam int unsigned W = FIELD_BITS;
    localparam int unsigned CW = $clog2(W + 1);

    localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_CHK = 5'd2, S_PSTEP = 5'd3,
        S_PWAIT = 5'd4, S_PSQ = 5'd5, S_PSQW = 5'd6, S_PRET = 5'd7, S_FACT = 5'd8,
        S_ZNEXT = 5'd9, S_TLOOP = 5'd10, S_SQW = 5'd11, S_BSQ = 5'd12, S_BSQW = 5'd13,
        S_MR = 5'd14, S_MRW = 5'd15, S_MC = 5'd16, S_MCW = 5'd17, S_MT = 5'd18,
        S_MTW = 5'd19, S_OUT = 5'd20;
    // what to do after an exponentiation
    localparam logic [2:0] P_LEG = 3'd0, P_R34 = 3'd1, P_Z = 3'd2, P_C = 3'd3,
        P_R = 3'd4, P_T = 3'd5;

    logic [63:0]  r_modulus;
    logic [4:0]   r_state;
    logic [2:0]   r_ret;
    logic [W-1:0] r_p, r_n, r_half, r_q, r_z, r_c, r_r, r_t, r_b;
    logic [W-1:0] r_base, r_exp, r_acc;
    logic [CW-1:0] r_s, r_m, r_i, r_k, r_cnt;
    logic [W-1:0] r_rem, r_div;
    logic [63:0]  r_o1, r_o2;
    logic [1:0]   r_st;
    logic         r_ovalid;

    logic         m_start, m_done;
    logic [W-1:0] m_a, m_b, m_prod;
    logic [W:0]   red_try;

    msqrt_mulmod #(.FIELD_BITS(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start), .i_a(m_a), .i_b(m_b),
        .i_p(r_p), .o_done(m_done), .o_prod(m_prod)
    );

    // operand selection for the shared multiplier
    always_comb begin
        m_start = 1'b0;
        m_a = r_acc;
        m_b = r_base;
        case (r_state)
            S_PSTEP: begin m_start = r_exp[0]; m_a = r_acc; m_b = r_base; end
            S_PSQ:   begin m_start = 1'b1; m_a = r_base; m_b = r_base; end
            S_TLOOP: begin m_start = (r_t != W'(1)); m_a = r_t; m_b = r_t; end
            S_SQW:   begin m_start = m_done && r_i < r_m && m_prod != W'(1);
                           m_a = m_prod; m_b = m_prod; end
            S_BSQ:   begin m_start = (r_k != '0); m_a = r_b; m_b = r_b; end
            S_MR:    begin m_start = 1'b1; m_a = r_r; m_b = r_b; end
            S_MC:    begin m_start = 1'b1; m_a = r_b; m_b = r_b; end
            S_MT:    begin m_start = 1'b1; m_a = r_t; m_b = r_c; end
            default: ;
        endcase
    end

    // restoring reduction step: remainder in r_rem, dividend bits shift out of r_div
    assign red_try = {r_rem, r_div[W-1]};

    assign i_in.ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid    = r_ovalid;
    assign o_out.root_one = r_o1;
    assign o_out.root_two = r_o2;
    assign o_out.status   = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= msqrt_pkg::MODULUS_RESET;
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_modulus <= i_cfg_data;
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_p   <= r_modulus[W-1:0];
                        r_div <= i_in.value[W-1:0];
                        r_rem <= '0;
                        r_cnt <= CW'(W);
                        if (r_modulus[W-1:0] < W'(2)) begin
                            r_o1 <= '0; r_o2 <= '0; r_st <= msqrt_pkg::ST_NONRES;
                            r_state <= S_OUT;
                        end else if (r_modulus[W-1:0] == W'(2)) begin
                            r_o1 <= 64'(i_in.value[0]); r_o2 <= 64'(i_in.value[0]);
                            r_st <= msqrt_pkg::ST_OK;
                            r_state <= S_OUT;
                        end else if (!r_modulus[0]) begin
                            r_o1 <= '0; r_o2 <= '0; r_st <= msqrt_pkg::ST_NONRES;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    r_div <= {r_div[W-2:0], 1'b0};
                    r_rem <= (red_try >= {1'b0, r_p}) ? W'(red_try - {1'b0, r_p})
                                                      : red_try[W-1:0];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) r_state <= S_CHK;
                end
                S_CHK: begin
                    r_n <= r_rem;
                    r_half <= r_p >> 1;
                    if (r_rem == '0) begin
                        r_o1 <= '0; r_o2 <= '0; r_st <= msqrt_pkg::ST_OK;
                        r_state <= S_OUT;
                    end else begin
                        r_base <= r_rem; r_exp <= r_p >> 1; r_acc <= W'(1);
                        r_ret <= P_LEG; r_state <= S_PSTEP;
                    end
                end
                // square-and-multiply
                S_PSTEP: begin
                    if (r_exp == '0) r_state <= S_PRET;
                    else if (r_exp[0]) r_state <= S_PWAIT;
                    else r_state <= S_PSQ;
                end
                S_PWAIT: if (m_done) begin r_acc <= m_prod; r_state <= S_PSQ; end
                S_PSQ: r_state <= S_PSQW;
                S_PSQW: if (m_done) begin
                    r_base <= m_prod; r_exp <= r_exp >> 1; r_state <= S_PSTEP;
                end
                S_PRET: begin
                    case (r_ret)
                        P_LEG: begin
                            if (r_acc != W'(1)) begin
                                r_o1 <= '0; r_o2 <= '0; r_st <= msqrt_pkg::ST_NONRES;
                                r_state <= S_OUT;
                            end else begin
                                r_q <= r_p >> 1; r_s <= CW'(1); r_state <= S_FACT;
                            end
                        end
                        P_R34: begin
                            r_r <= r_acc; r_st <= msqrt_pkg::ST_OK; r_state <= S_OUT;
                            r_o1 <= 64'(r_acc);
                            r_o2 <= (r_acc == '0) ? 64'd0 : 64'(r_p - r_acc);
                        end
                        P_Z: begin
                            if (r_acc != '0 && r_acc != W'(1)) begin
                                r_base <= r_z; r_exp <= r_q; r_acc <= W'(1);
                                r_ret <= P_C; r_state <= S_PSTEP;
                            end else begin
                                r_z <= r_z + W'(1); r_state <= S_ZNEXT;
                            end
                        end
                        P_C: begin
                            r_c <= r_acc; r_base <= r_n; r_exp <= (r_q >> 1) + W'(1);
                            r_acc <= W'(1); r_ret <= P_R; r_state <= S_PSTEP;
                        end
                        P_R: begin
                            r_r <= r_acc; r_base <= r_n; r_exp <= r_q;
                            r_acc <= W'(1); r_ret <= P_T; r_state <= S_PSTEP;
                        end
                        default: begin
                            r_t <= r_acc; r_m <= r_s; r_state <= S_TLOOP;
                        end
                    endcase
                end
                // strip factors of two from p-1
                S_FACT: begin
                    if (!r_q[0]) begin
                        r_q <= r_q >> 1; r_s <= r_s + 1'b1;
                    end else if (r_s == CW'(1)) begin
                        r_base <= r_n; r_exp <= (r_p >> 2) + W'(1); r_acc <= W'(1);
                        r_ret <= P_R34; r_state <= S_PSTEP;
                    end else begin
                        r_z <= W'(2); r_state <= S_ZNEXT; r_ret <= P_Z;
                        r_acc <= W'(1);
                    end
                end
                // try candidate z unless the search range is used up
                S_ZNEXT: begin
                    if (r_z >= r_p || 64'(r_z) >= 64'(msqrt_pkg::NONRES_LIMIT)) begin
                        r_o1 <= '0; r_o2 <= '0; r_st <= msqrt_pkg::ST_FAIL;
                        r_state <= S_OUT;
                    end else begin
                        r_base <= r_z; r_exp <= r_half; r_acc <= W'(1);
                        r_ret <= P_Z; r_state <= S_PSTEP;
                    end
                end
                S_TLOOP: begin
                    if (r_t == W'(1)) begin
                        r_o1 <= 64'(r_r);
                        r_o2 <= (r_r == '0) ? 64'd0 : 64'(r_p - r_r);
                        r_st <= msqrt_pkg::ST_OK; r_state <= S_OUT;
                    end else begin
                        r_i <= CW'(1); r_state <= S_SQW;
                    end
                end
                S_SQW: if (m_done) begin
                    if (r_i >= r_m) begin
                        r_o1 <= '0; r_o2 <= '0; r_st <= msqrt_pkg::ST_FAIL;
                        r_state <= S_OUT;
                    end else if (m_prod == W'(1)) begin
                        r_b <= r_c; r_k <= r_m - r_i - 1'b1; r_state <= S_BSQ;
                    end else r_i <= r_i + 1'b1;
                end
                S_BSQ: r_state <= (r_k != '0) ? S_BSQW : S_MR;
                S_BSQW: if (m_done) begin
                    r_b <= m_prod; r_k <= r_k - 1'b1; r_state <= S_BSQ;
                end
                S_MR: r_state <= S_MRW;
                S_MRW: if (m_done) begin r_r <= m_prod; r_state <= S_MC; end
                S_MC: r_state <= S_MCW;
                S_MCW: if (m_done) begin r_c <= m_prod; r_state <= S_MT; end
                S_MT: r_state <= S_MTW;
                S_MTW: if (m_done) begin
                    r_t <= m_prod; r_m <= r_i; r_state <= S_TLOOP;
                end
                S_OUT: begin
                    if (!r_ovalid) begin r_ovalid <= 1'b1; r_state <= S_IDLE; end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/msqrt_checker.sv
`default_nettype none
module msqrt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        o_valid,
    input wire logic        o_ready,
    input wire logic [63:0] o_root_one,
    input wire logic [63:0] o_root_two,
    input wire logic [1:0]  o_status
);
    // not ready while a result beat waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !i_ready) else $error("ready with result pending");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_root_one)) else $error("result dropped");
    // status code legal
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
    // failure gives zero roots
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_root_one == 64'd0 && o_root_two == 64'd0)
        else $error("roots on failure");
endmodule

bind modular_square_root msqrt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid), .i_ready(i_in.ready),
    .o_valid(o_out.valid), .o_ready(o_out.ready), .o_root_one(o_out.root_one),
    .o_root_two(o_out.root_two), .o_status(o_out.status)
);
`default_nettype wire
